### sv/assert_macros.svh
// assertion macros for the color wheel core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

### sv/fcwc_pkg.sv
// package: widths, cordic table and color wheel function
`timescale 1ns / 1ps
package fcwc_pkg;
  localparam int FLOW_FRAC_BITS_DEF = 12;
  localparam int WHEEL_ENTRIES_DEF = 55;
  localparam int CORDIC_ITERS = 20;
  localparam int ANGLE_BITS = 24;
  localparam int WEIGHT_BITS = 16;
  localparam int CW = 32;

  typedef logic [7:0] byte_t;
  typedef struct packed {
    byte_t r;
    byte_t g;
    byte_t b;
  } rgb_t;

  function automatic logic signed [CW-1:0] atan_unit(input int i);
    logic signed [CW-1:0] t;
    case (i)
      0: t = 32'sd2097152;  1: t = 32'sd1238021;  2: t = 32'sd654136;
      3: t = 32'sd332050;   4: t = 32'sd166669;   5: t = 32'sd83416;
      6: t = 32'sd41718;    7: t = 32'sd20860;    8: t = 32'sd10430;
      9: t = 32'sd5215;     10: t = 32'sd2608;    11: t = 32'sd1304;
      12: t = 32'sd652;     13: t = 32'sd326;     14: t = 32'sd163;
      15: t = 32'sd81;      16: t = 32'sd41;      17: t = 32'sd20;
      18: t = 32'sd10;      19: t = 32'sd5;
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic rgb_t wheel_color(input logic [5:0] k);
    rgb_t c;
    int kk;
    int up;
    kk = int'(k);
    c = '{8'd255, 8'd0, 8'd0};
    if (kk < 15) begin
      up = 255 * kk / 15; c = '{8'd255, byte_t'(up), 8'd0};
    end else if (kk < 21) begin
      up = 255 * (kk - 15) / 6; c = '{byte_t'(255 - up), 8'd255, 8'd0};
    end else if (kk < 25) begin
      up = 255 * (kk - 21) / 4; c = '{8'd0, 8'd255, byte_t'(up)};
    end else if (kk < 36) begin
      up = 255 * (kk - 25) / 11; c = '{8'd0, byte_t'(255 - up), 8'd255};
    end else if (kk < 49) begin
      up = 255 * (kk - 36) / 13; c = '{byte_t'(up), 8'd0, 8'd255};
    end else if (kk < 55) begin
      up = 255 * (kk - 49) / 6; c = '{8'd255, 8'd0, byte_t'(255 - up)};
    end
    return c;
  endfunction
endpackage

### sv/flow_color_wheel_code_core.sv
// top level: flow vector to color wheel rgb pixel
// One item enters per clock while the output is not stalled. The pipeline has one stage for
// the squares, one per cordic iteration and square-root step (run side by side, 20 stages,
// the root padded by delay registers), then one stage each for the phase and index, the wheel
// lookup, the blend, the magnitude product and the output register. A stall on the output
// holds every stage; the input is ready whenever the output register is empty or being taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module flow_color_wheel_code_core #(
  parameter int FLOW_FRAC_BITS = fcwc_pkg::FLOW_FRAC_BITS_DEF,
  parameter int WHEEL_ENTRIES = fcwc_pkg::WHEEL_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // flow_x[15:0], flow_y[31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // red_out[7:0], green_out[15:8], blue_out[23:16]
);
  localparam int CW = fcwc_pkg::CW;
  localparam int NI = fcwc_pkg::CORDIC_ITERS;
  localparam int NS = NI + 5;
  localparam int SH = FLOW_FRAC_BITS + fcwc_pkg::WEIGHT_BITS;
  localparam int AB = fcwc_pkg::ANGLE_BITS;
  localparam int WB = fcwc_pkg::WEIGHT_BITS;

  logic adv;
  logic [NS-1:0] vld;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // stage 0: squares and cordic setup
  logic signed [CW-1:0] u [0:NI];
  logic signed [CW-1:0] v [0:NI];
  logic signed [CW-1:0] z [0:NI];
  logic [CW-1:0] rs [0:16];
  logic [CW-1:0] rr [0:16];
  logic in_r [0:NI+4];
  logic zv [0:NI];

  logic signed [15:0] fx, fy;
  logic signed [CW-1:0] nu, nv;
  logic [CW:0] sq;
  assign fx = s_axis_tdata[15:0];
  assign fy = s_axis_tdata[31:16];
  assign nu = -(CW'(fx) <<< 10);
  assign nv = -(CW'(fy) <<< 10);
  assign sq = (CW+1)'(unsigned'(CW'(fx) * CW'(fx))) + (CW+1)'(unsigned'(CW'(fy) * CW'(fy)));

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NS-2:0], s_axis_tvalid};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zv[0] <= (fx == 0) && (fy == 0);
      in_r[0] <= sq <= ((CW+1)'(1) << (2 * FLOW_FRAC_BITS));
      rs[0] <= sq[CW-1:0];
      rr[0] <= '0;
      if (nu < 0) begin
        u[0] <= -nu; v[0] <= -nv;
        z[0] <= (nv > 0) ? (CW'(1) <<< (AB - 1)) : -(CW'(1) <<< (AB - 1));
      end else begin
        u[0] <= nu; v[0] <= nv; z[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NI; i++) begin : g_cor
    always_ff @(posedge clk) begin
      if (adv) begin
        zv[i+1] <= zv[i];
        in_r[i+1] <= in_r[i];
        if (v[i] >= 0) begin
          u[i+1] <= u[i] + (v[i] >>> i); v[i+1] <= v[i] - (u[i] >>> i);
          z[i+1] <= z[i] + fcwc_pkg::atan_unit(i);
        end else begin
          u[i+1] <= u[i] - (v[i] >>> i); v[i+1] <= v[i] + (u[i] >>> i);
          z[i+1] <= z[i] - fcwc_pkg::atan_unit(i);
        end
      end
    end
  end

  for (genvar i = 0; i < 16; i++) begin : g_sqrt
    localparam logic [CW-1:0] BIT = CW'(1) << (30 - 2 * i);
    always_ff @(posedge clk) begin
      if (adv) begin
        if (rs[i] >= rr[i] + BIT) begin
          rs[i+1] <= rs[i] - (rr[i] + BIT); rr[i+1] <= (rr[i] >> 1) + BIT;
        end else begin
          rs[i+1] <= rs[i]; rr[i+1] <= rr[i] >> 1;
        end
      end
    end
  end

  // root delay to match cordic depth
  logic [16:0] rd [17:NI];
  always_ff @(posedge clk) begin
    if (adv) rd[17] <= rr[16][16:0];
  end
  for (genvar i = 17; i < NI; i++) begin : g_rd
    always_ff @(posedge clk) begin
      if (adv) rd[i+1] <= rd[i];
    end
  end

  // phase, index and weight
  logic signed [CW-1:0] pz;
  logic [AB:0] pc;
  assign pz = (zv[NI] ? CW'(0) : z[NI]) + (CW'(1) <<< (AB - 1));
  assign pc = (pz < 0) ? '0 : (pz > (CW'(1) <<< AB)) ? (AB+1)'(1) << AB : pz[AB:0];

  logic [AB+6:0] q;
  logic [16:0] r1, r2, r3;
  always_ff @(posedge clk) begin
    if (adv) begin
      q <= (AB+7)'(pc) * (AB+7)'(WHEEL_ENTRIES - 1);
      r1 <= rd[NI];
      in_r[NI+1] <= in_r[NI];
    end
  end

  logic [5:0] k0, k1;
  assign k0 = (q[AB+6:AB] > 7'(WHEEL_ENTRIES - 1)) ? 6'(WHEEL_ENTRIES - 1) : q[AB+5:AB];
  assign k1 = (k0 + 6'd1 >= 6'(WHEEL_ENTRIES)) ? 6'd0 : k0 + 6'd1;

  // constant wheel table
  fcwc_pkg::rgb_t wheel_rom [0:63];
  for (genvar k = 0; k < 64; k++) begin : g_wheel
    assign wheel_rom[k] = fcwc_pkg::wheel_color(6'(k));
  end

  fcwc_pkg::rgb_t c0, c1;
  logic [WB-1:0] f;
  always_ff @(posedge clk) begin
    if (adv) begin
      c0 <= wheel_rom[k0];
      c1 <= wheel_rom[k1];
      f <= q[AB-1:AB-WB];
      r2 <= r1;
      in_r[NI+2] <= in_r[NI+1];
    end
  end

  logic [23:0] cq [0:2];
  always_ff @(posedge clk) begin
    if (adv) begin
      cq[0] <= 24'(24'(c0.r) * ((25'(1) << WB) - 25'(f)) + 24'(c1.r) * 24'(f));
      cq[1] <= 24'(24'(c0.g) * ((25'(1) << WB) - 25'(f)) + 24'(c1.g) * 24'(f));
      cq[2] <= 24'(24'(c0.b) * ((25'(1) << WB) - 25'(f)) + 24'(c1.b) * 24'(f));
      r3 <= r2;
      in_r[NI+3] <= in_r[NI+2];
    end
  end

  logic [40:0] dp [0:2];
  logic [23:0] cq2 [0:2];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        dp[c] <= 41'(r3) * 41'((24'd255 << WB) - cq[c]);
        cq2[c] <= cq[c];
      end
      in_r[NI+4] <= in_r[NI+3];
    end
  end

  logic [7:0] ob [0:2];
  logic [41:0] top;
  logic [25:0] s3 [0:2];
  assign top = 42'd255 << SH;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s3[c] = (26'(cq2[c]) * 26'd3) >> (WB + 2);
      if (in_r[NI+4])
        ob[c] = (42'(dp[c]) >= top) ? 8'd0 : 8'((top - 42'(dp[c])) >> SH);
      else
        ob[c] = (s3[c] > 26'd255) ? 8'd255 : s3[c][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (adv) m_axis_tvalid <= vld[NS-1];
  end
  always_ff @(posedge clk) begin
    if (adv) m_axis_tdata <= {ob[2], ob[1], ob[0]};
  end

  `ASSERT_CLK(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output item changed under stall")
  `ASSERT_CLK(a_ready, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready mismatch")
  `ASSERT_RST(a_rst, rst |=> !m_axis_tvalid, "valid after reset")
endmodule

### tb/testbench.sv
// testbench for the flow color wheel core: random and edge flow vectors vs a bit-exact predictor
`timescale 1ns / 1ps
module testbench;

  localparam int FRAC = fcwc_pkg::FLOW_FRAC_BITS_DEF;
  localparam int NWHEEL = fcwc_pkg::WHEEL_ENTRIES_DEF;

  class pixel_board;
    logic [23:0] pending[$];
    int errors = 0;
    int checked = 0;

    function automatic logic [23:0] ramp_rgb(int k);
      int lens[6] = '{15, 6, 4, 11, 13, 6};
      int seg;
      int up;
      int dn;
      logic [7:0] r, g, b;
      seg = 0;
      while (seg < 6 && k >= lens[seg]) begin
        k -= lens[seg];
        seg++;
      end
      r = 8'd255; g = 8'd0; b = 8'd0;
      if (seg < 6) begin
        up = 255 * k / lens[seg];
        dn = 255 - up;
        case (seg)
          0: begin r = 8'd255; g = 8'(up); b = 8'd0; end
          1: begin r = 8'(dn); g = 8'd255; b = 8'd0; end
          2: begin r = 8'd0; g = 8'd255; b = 8'(up); end
          3: begin r = 8'd0; g = 8'(dn); b = 8'd255; end
          4: begin r = 8'(up); g = 8'd0; b = 8'd255; end
          default: begin r = 8'd255; g = 8'd0; b = 8'(dn); end
        endcase
      end
      return {b, g, r};
    endfunction

    function automatic longint floor_shift(longint a, int s);
      return a >>> s;
    endfunction

    function automatic logic [23:0] color_of(logic signed [15:0] fx, logic signed [15:0] fy);
      longint x, y, s, res, bit_v, u, v, z, du, dv, p, q, k0, k1, f, cq, d, top, val;
      longint atn[20] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
                          10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};
      logic [23:0] c0, c1, outp;
      bit inner;
      x = fx; y = fy;
      s = x * x + y * y;
      inner = s <= (64'sd1 << (2 * FRAC));
      res = 0;
      if (inner) begin
        bit_v = 64'sd1 << 30;
        for (int i = 0; i < 16; i++) begin
          if (s >= res + bit_v) begin
            s -= res + bit_v;
            res = (res >> 1) + bit_v;
          end else begin
            res = res >> 1;
          end
          bit_v = bit_v >> 2;
        end
      end
      u = -x * 1024; v = -y * 1024; z = 0;
      if (!(u == 0 && v == 0)) begin
        if (u < 0) begin
          z = (v > 0) ? (64'sd1 <<< 23) : -(64'sd1 <<< 23);
          u = -u; v = -v;
        end
        for (int i = 0; i < 20; i++) begin
          du = floor_shift(v, i);
          dv = floor_shift(u, i);
          if (v >= 0) begin
            u += du; v -= dv; z += atn[i];
          end else begin
            u -= du; v += dv; z -= atn[i];
          end
        end
      end
      p = z + (64'sd1 <<< 23);
      if (p < 0) p = 0;
      if (p > (64'sd1 <<< 24)) p = 64'sd1 <<< 24;
      q = p * (NWHEEL - 1);
      k0 = q >> 24;
      if (k0 > NWHEEL - 1) k0 = NWHEEL - 1;
      k1 = (k0 + 1 >= NWHEEL) ? 0 : k0 + 1;
      f = (q >> 8) & 16'hFFFF;
      c0 = ramp_rgb(int'(k0));
      c1 = ramp_rgb(int'(k1));
      for (int ch = 0; ch < 3; ch++) begin
        cq = longint'(c0[8*ch +: 8]) * (65536 - f) + longint'(c1[8*ch +: 8]) * f;
        if (inner) begin
          top = 64'sd255 <<< (FRAC + 16);
          d = res * (255 * 65536 - cq);
          val = (d >= top) ? 0 : ((top - d) >> (FRAC + 16));
        end else begin
          val = (cq * 3) >> 18;
        end
        if (val > 255) val = 255;
        outp[8*ch +: 8] = val[7:0];
      end
      return outp;
    endfunction

    function void note_input(logic [31:0] data);
      pending.push_back(color_of(data[15:0], data[31:16]));
    endfunction

    function void check_pixel(logic [23:0] got);
      logic [23:0] want;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected pixel %h", got);
        return;
      end
      want = pending.pop_front();
      for (int ch = 0; ch < 3; ch++) begin
        if (want[8*ch +: 8] !== got[8*ch +: 8]) begin
          errors++;
          if (errors <= 10)
            $display("channel %0d: expected %0d got %0d", ch, want[8*ch +: 8], got[8*ch +: 8]);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [23:0] m_axis_tdata;

  pixel_board board = new();
  int send_idle = 16;
  int recv_idle = 68;
  bit hold_recv = 0;
  int sent = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  flow_color_wheel_code_core u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_pixel(m_axis_tdata);
    m_axis_tready <= !rst && !hold_recv && ($urandom_range(99) >= recv_idle);
  end

  task automatic send_flow(logic signed [15:0] fx, logic signed [15:0] fy);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {fy, fx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_input({fy, fx});
    sent++;
  endtask

  task automatic random_flow();
    logic signed [15:0] fx, fy;
    case ($urandom_range(3))
      0: begin fx = 16'($urandom); fy = 16'($urandom); end
      1: begin
        fx = 16'($signed($urandom_range(2 * 4096)) - 4096);
        fy = 16'($signed($urandom_range(2 * 4096)) - 4096);
      end
      2: begin
        fx = 16'($signed($urandom_range(5800)) - 2900);
        fy = 16'($signed($urandom_range(5800)) - 2900);
      end
      default: begin
        fx = 16'($signed($urandom_range(64)) - 32);
        fy = $urandom_range(1) ? 16'sd0 : 16'($signed($urandom_range(8)) - 4);
      end
    endcase
    send_flow(fx, fy);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic signed [15:0] edges[10] = '{16'sh8000, 16'sh7fff, 0, 1, -1, 4096, -4096,
                                      4095, 4097, 2896};
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // corners, axes, unit circle boundary
    for (int i = 0; i < 5; i++) send_flow(edges[2*i], edges[2*i+1]);
    send_flow(0, 0);
    send_flow(4096, 0);
    send_flow(-4096, 0);
    send_flow(0, 4096);
    send_flow(0, -4096);
    send_flow(5, 0);
    send_flow(-5, 0);
    send_flow(2896, 2896);
    send_flow(-2896, 2897);
    send_flow(16'sh7fff, 16'sh8000);
    send_flow(16'sh8000, 16'sh8000);
    send_flow(16'sh7fff, 16'sh7fff);
    send_flow(16'sh5555, 16'shaaaa);
    send_flow(3, -1);
    send_flow(-3, 1);
    // output held off long while input keeps coming
    hold_recv = 1;
    fork
      begin
        repeat (200) @(posedge clk);
        hold_recv = 0;
      end
      begin
        for (int i = 0; i < 60; i++) random_flow();
        s_axis_tvalid <= 0;
      end
    join
    drain();
    for (int i = 0; i < 500; i++) random_flow();
    s_axis_tvalid <= 0;
    drain();
    send_idle = 68; recv_idle = 16;
    for (int i = 0; i < 500; i++) random_flow();
    send_idle = 0; recv_idle = 0;
    for (int i = 0; i < 470; i++) random_flow();
    s_axis_tvalid <= 0;
    drain();
    repeat (40) @(posedge clk);
    $display("sent %0d flow vectors, checked %0d pixels, incl. axes, corners and stalls",
             sent, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d errors, %0d pixels missing", board.errors, board.pending.size());
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("Mismatches found");
    $finish;
  end
endmodule

### flow_color_wheel_code_core.f
+incdir+sv
sv/fcwc_pkg.sv
sv/flow_color_wheel_code_core.sv
tb/testbench.sv
